### sv/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared widths, codes and controller/datapath interface types of the
// tabulated CDF interpolator.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int XY_W    = 32;  // Q16.16 coordinate
  localparam int P_W     = 16;  // Q0.16 probability
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int TGT_W   = 34;  // inverse target, first y plus scaled span

  // Multiply-divide unit widths.
  localparam int MA_W      = 35;  // signed first factor
  localparam int MAG_A_W   = 34;  // its magnitude
  localparam int MB_W      = 33;  // signed second factor and divisor
  localparam int MUL_LO_W  = 17;  // low slice of the first factor
  localparam int MUL_HI_W  = MAG_A_W - MUL_LO_W;
  localparam int PPROD_W   = MUL_LO_W + MB_W;
  localparam int PROD_W    = MAG_A_W + MB_W;
  localparam int QUOT_BITS = 40;
  localparam int MQ_W      = QUOT_BITS + 1;
  localparam int SUM_W     = MQ_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVERSE = 2'd2;

  localparam logic [ST_W-1:0] ST_VALID  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_LOADED = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RES_ERR,
    OP_RD_LAST,
    OP_SAVE_LAST,
    OP_RD_FIRST,
    OP_SAVE_FIRST,
    OP_RD_SCAN,
    OP_STEP,
    OP_RES_CUR,
    OP_MD_PREP,
    OP_MD_START,
    OP_RES_MD
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             slot_ok;
    logic             empty;
    logic             above_last;
    logic             hit;
    logic             above_cur;
    logic             idx_first;
    logic             idx_last;
    logic             md_done;
  } dp_status_t;

endpackage

### sv/tci_muldiv.sv
// ----------------------------------------------------------------------------
// tci_muldiv
// Multi-cycle trunc(a*b/d): two-slice multiply, saturation check, then a
// restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tci_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tci_pkg::MA_W-1:0]   a,
  input  logic [tci_pkg::MB_W-1:0]   b,
  input  logic [tci_pkg::MB_W-1:0]   d,
  output logic                       done,
  output logic                       neg,
  output logic [tci_pkg::MQ_W-1:0]   q
);
  import tci_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL_LO,
    M_MUL_HI,
    M_SUM,
    M_CHECK,
    M_DIV
  } mstate_t;

  localparam logic [5:0] LAST_STEP = 6'(QUOT_BITS - 1);

  mstate_t              state;
  logic [MAG_A_W-1:0]   ua;
  logic [MB_W-1:0]      ub;
  logic [MB_W-1:0]      ud;
  logic [PPROD_W-1:0]   plo;
  logic [PPROD_W-1:0]   phi;
  logic [PROD_W-1:0]    prod;
  logic [MB_W-1:0]      rem;
  logic [QUOT_BITS-1:0] dvd;
  logic [5:0]           step;

  logic [MA_W-1:0]      a_abs;
  logic [MB_W-1:0]      b_abs;
  logic [MB_W-1:0]      d_abs;
  logic [MB_W:0]        rem_sh;
  logic [MB_W:0]        rem_sub;
  logic                 fits;
  logic                 sat;

  always_comb begin
    a_abs   = a[MA_W-1] ? -a : a;
    b_abs   = b[MB_W-1] ? -b : b;
    d_abs   = d[MB_W-1] ? -d : d;
    rem_sh  = {rem, dvd[QUOT_BITS-1]};
    rem_sub = rem_sh - {1'b0, ud};
    fits    = rem_sh >= {1'b0, ud};
    sat     = {{(QUOT_BITS + MB_W - PROD_W){1'b0}}, prod} >= {ud, {QUOT_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            ua    <= a_abs[MAG_A_W-1:0];
            ub    <= b_abs;
            ud    <= d_abs;
            neg   <= a[MA_W-1] ^ b[MB_W-1] ^ d[MB_W-1];
            state <= M_MUL_LO;
          end
        end
        M_MUL_LO: begin
          plo   <= ua[MUL_LO_W-1:0] * ub;
          state <= M_MUL_HI;
        end
        M_MUL_HI: begin
          phi   <= PPROD_W'(ua[MAG_A_W-1:MUL_LO_W] * ub);
          state <= M_SUM;
        end
        M_SUM: begin
          prod  <= {phi[MUL_HI_W+MB_W-1:0], {MUL_LO_W{1'b0}}}
                   + {{(PROD_W - PPROD_W){1'b0}}, plo};
          state <= M_CHECK;
        end
        M_CHECK: begin
          if (ud == '0) begin
            // A zero divisor yields a zero quotient.
            q     <= '0;
            done  <= 1'b1;
            state <= M_IDLE;
          end else if (sat) begin
            q     <= {1'b1, {QUOT_BITS{1'b0}}};
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            rem   <= {{(MB_W - (PROD_W - QUOT_BITS)){1'b0}}, prod[PROD_W-1:QUOT_BITS]};
            dvd   <= prod[QUOT_BITS-1:0];
            q     <= '0;
            step  <= '0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          rem  <= fits ? rem_sub[MB_W-1:0] : rem_sh[MB_W-1:0];
          dvd  <= {dvd[QUOT_BITS-2:0], 1'b0};
          q    <= {q[MQ_W-2:0], fits};
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

### sv/tci_datapath.sv
// ----------------------------------------------------------------------------
// tci_datapath
// Point memory, item capture, scan registers, inverse target pipeline,
// interpolation arithmetic and the result registers.
// ----------------------------------------------------------------------------
module tci_datapath #(
  parameter int TABLE_DEPTH = tci_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tci_pkg::CMD_W-1:0]   command,
  input  logic [tci_pkg::IDX_W-1:0]   entry_index,
  input  logic [tci_pkg::XY_W-1:0]    entry_x,
  input  logic [tci_pkg::XY_W-1:0]    entry_y,
  input  logic [tci_pkg::XY_W-1:0]    query_x,
  input  logic [tci_pkg::P_W-1:0]     query_p,
  input  logic                        config_write,
  input  logic [tci_pkg::CFG_W-1:0]   config_data,
  input  tci_pkg::dp_cmd_t            cmd,
  output tci_pkg::dp_status_t         stat,
  output logic                        done,
  output logic [tci_pkg::XY_W-1:0]    value,
  output logic [tci_pkg::ST_W-1:0]    status
);
  import tci_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic [2*XY_W-1:0]  mem [TABLE_DEPTH];
  logic [2*XY_W-1:0]  rd_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  logic [CMD_W-1:0]   cap_cmd;
  logic [IDX_W-1:0]   cap_index;
  logic [XY_W-1:0]    cap_x;
  logic [XY_W-1:0]    cap_y;
  logic [XY_W-1:0]    cap_qx;
  logic [P_W-1:0]     cap_qp;

  logic [CNT_W-1:0]   used_cnt;
  logic [ADDR_W-1:0]  last_idx;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  waddr;

  logic [XY_W-1:0]    last_x;
  logic [XY_W-1:0]    last_y;
  logic [XY_W-1:0]    first_y;
  logic [XY_W-1:0]    prev_x;
  logic [XY_W-1:0]    prev_y;
  logic [XY_W-1:0]    span;
  logic [XY_W+P_W-1:0] sprod;
  logic [TGT_W-1:0]   target;

  logic [MA_W-1:0]    md_a;
  logic [MB_W-1:0]    md_b;
  logic [MB_W-1:0]    md_d;
  logic [XY_W-1:0]    md_base;
  logic               md_done;
  logic               md_neg;
  logic [MQ_W-1:0]    md_q;

  logic [XY_W-1:0]    rd_x;
  logic [XY_W-1:0]    rd_y;
  logic               is_fwd;
  logic [XY_W:0]      span_diff;
  logic [XY_W:0]      span_neg;
  logic [MB_W-1:0]    dx;
  logic [MB_W-1:0]    dy;
  logic [SUM_W-1:0]   q_signed;
  logic [SUM_W-1:0]   sum;
  logic [XY_W-1:0]    sum_sat;

  always_comb begin
    rd_x      = rd_data[2*XY_W-1:XY_W];
    rd_y      = rd_data[XY_W-1:0];
    is_fwd    = cap_cmd == CMD_FORWARD;
    last_idx  = ADDR_W'(used_cnt - CNT_W'(1));
    waddr     = ADDR_W'(cap_index);
    span_diff = {last_y[XY_W-1], last_y} - {first_y[XY_W-1], first_y};
    span_neg  = -span_diff;
    dx        = {rd_x[XY_W-1], rd_x} - {prev_x[XY_W-1], prev_x};
    dy        = {rd_y[XY_W-1], rd_y} - {prev_y[XY_W-1], prev_y};
    q_signed  = md_neg ? -{1'b0, md_q} : {1'b0, md_q};
    sum       = {{(SUM_W - XY_W){md_base[XY_W-1]}}, md_base} + q_signed;
    // The sum fits when the sign bit and all bits above it agree.
    if (sum[SUM_W-1:XY_W-1] == '0 || sum[SUM_W-1:XY_W-1] == '1) begin
      sum_sat = sum[XY_W-1:0];
    end else begin
      sum_sat = sum[SUM_W-1] ? {1'b1, {(XY_W-1){1'b0}}} : {1'b0, {(XY_W-1){1'b1}}};
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx;
    case (cmd.op)
      OP_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      OP_RD_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_RD_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    stat.command    = cap_cmd;
    stat.slot_ok    = 32'(cap_index) < 32'(TABLE_DEPTH);
    stat.empty      = used_cnt == '0;
    stat.above_last = $signed(cap_qx) > $signed(last_x);
    stat.hit        = is_fwd ? ($signed(rd_x) >= $signed(cap_qx))
                             : ($signed({{(TGT_W - XY_W){rd_y[XY_W-1]}}, rd_y})
                                >= $signed(target));
    stat.above_cur  = $signed(rd_x) > $signed(cap_qx);
    stat.idx_first  = idx == '0;
    stat.idx_last   = idx == last_idx;
    stat.md_done    = md_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[waddr] <= {cap_x, cap_y};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt <= '0;
    end else if (config_write) begin
      if (32'(config_data) > 32'(TABLE_DEPTH)) begin
        used_cnt <= CNT_W'(TABLE_DEPTH);
      end else begin
        used_cnt <= CNT_W'(config_data);
      end
    end
  end

  // Target pipeline runs freely; the controller waits it out after the
  // first point is saved.
  always_ff @(posedge clk) begin
    span   <= span_diff[XY_W] ? span_neg[XY_W-1:0] : span_diff[XY_W-1:0];
    sprod  <= span * cap_qp;
    target <= {{(TGT_W - XY_W){first_y[XY_W-1]}}, first_y}
              + {{(TGT_W - XY_W){1'b0}}, sprod[XY_W+P_W-1:P_W]};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_cmd   <= command;
      cap_index <= entry_index;
      cap_x     <= entry_x;
      cap_y     <= entry_y;
      cap_qx    <= query_x;
      cap_qp    <= query_p;
    end
    case (cmd.op)
      OP_SAVE_LAST: begin
        last_x <= rd_x;
        last_y <= rd_y;
      end
      OP_SAVE_FIRST: begin
        first_y <= rd_y;
        idx     <= '0;
      end
      OP_STEP: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
        idx    <= idx + ADDR_W'(1);
      end
      OP_MD_PREP: begin
        if (is_fwd) begin
          md_a    <= {{(MA_W - XY_W){cap_qx[XY_W-1]}}, cap_qx}
                     - {{(MA_W - XY_W){prev_x[XY_W-1]}}, prev_x};
          md_b    <= dy;
          md_d    <= dx;
          md_base <= prev_y;
        end else begin
          md_a    <= {{(MA_W - TGT_W){target[TGT_W-1]}}, target}
                     - {{(MA_W - XY_W){prev_y[XY_W-1]}}, prev_y};
          md_b    <= dx;
          md_d    <= dy;
          md_base <= prev_x;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.op == OP_LOAD || cmd.op == OP_RES_ERR ||
              cmd.op == OP_RES_CUR || cmd.op == OP_RES_MD;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        value  <= '0;
        status <= ST_LOADED;
      end
      OP_RES_ERR: begin
        value  <= '0;
        status <= ST_RANGE;
      end
      OP_RES_CUR: begin
        value  <= is_fwd ? rd_y : rd_x;
        status <= ST_VALID;
      end
      OP_RES_MD: begin
        value  <= sum_sat;
        status <= ST_VALID;
      end
      default: ;
    endcase
  end

  tci_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_MD_START),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .neg   (md_neg),
    .q     (md_q)
  );

endmodule

### sv/tci_ctrl.sv
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer for load, forward and inverse items: reads the end points,
// scans the table one point at a time and launches the interpolation.
// ----------------------------------------------------------------------------
module tci_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output tci_pkg::dp_cmd_t     cmd,
  input  tci_pkg::dp_status_t  stat
);
  import tci_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GET_LAST,
    S_RD_FIRST,
    S_GET_FIRST,
    S_SPAN,
    S_PROD,
    S_TGT,
    S_RANGE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MD_START,
    S_MD_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.command)
          CMD_LOAD: begin
            cmd.op     = stat.slot_ok ? OP_LOAD : OP_RES_ERR;
            state_next = S_IDLE;
          end
          CMD_FORWARD, CMD_INVERSE: begin
            if (stat.empty) begin
              cmd.op     = OP_RES_ERR;
              state_next = S_IDLE;
            end else begin
              cmd.op     = OP_RD_LAST;
              state_next = S_GET_LAST;
            end
          end
          default: begin
            cmd.op     = OP_RES_ERR;
            state_next = S_IDLE;
          end
        endcase
      end
      S_GET_LAST: begin
        cmd.op     = OP_SAVE_LAST;
        state_next = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        cmd.op     = OP_RD_FIRST;
        state_next = S_GET_FIRST;
      end
      S_GET_FIRST: begin
        cmd.op     = OP_SAVE_FIRST;
        state_next = S_SPAN;
      end
      S_SPAN: state_next = S_PROD;
      S_PROD: state_next = S_TGT;
      S_TGT:  state_next = S_RANGE;
      S_RANGE: begin
        if (stat.command == CMD_FORWARD && stat.above_last) begin
          cmd.op     = OP_RES_ERR;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_RD_SCAN;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_RD: begin
        cmd.op     = OP_RD_SCAN;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.hit) begin
          if (stat.idx_first) begin
            // A forward query below the first point is out of range.
            if (stat.command == CMD_FORWARD && stat.above_cur) begin
              cmd.op = OP_RES_ERR;
            end else begin
              cmd.op = OP_RES_CUR;
            end
            state_next = S_IDLE;
          end else begin
            cmd.op     = OP_MD_PREP;
            state_next = S_MD_START;
          end
        end else if (stat.idx_last) begin
          cmd.op     = OP_RES_ERR;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_STEP;
          state_next = S_SCAN_RD;
        end
      end
      S_MD_START: begin
        cmd.op     = OP_MD_START;
        state_next = S_MD_WAIT;
      end
      S_MD_WAIT: begin
        if (stat.md_done) begin
          cmd.op     = OP_RES_MD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

### sv/tabulated_cdf_interpolator.sv
// ----------------------------------------------------------------------------
// tabulated_cdf_interpolator
// Piecewise-linear table of signed Q16.16 points with forward (x to y) and
// inverse (probability to x) lookups.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on value and status for one cycle with done high and cannot be
// held off. A load is written in the decode state that follows capture,
// and its done is registered from that state. A lookup reads the last
// and first points, then scans the points from slot zero through the
// single memory read port, with a read state and a check state per point;
// if it ends between two points, a multiply and a 40-step restoring divide
// follow. Results that end the scan early arrive sooner. A new item can be
// taken in the cycle its predecessor's result is shown.
module tabulated_cdf_interpolator #(
  parameter int TABLE_DEPTH = tci_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tci_pkg::CMD_W-1:0]   command,
  input  logic [tci_pkg::IDX_W-1:0]   entry_index,
  input  logic [tci_pkg::XY_W-1:0]    entry_x,
  input  logic [tci_pkg::XY_W-1:0]    entry_y,
  input  logic [tci_pkg::XY_W-1:0]    query_x,
  input  logic [tci_pkg::P_W-1:0]     query_p,
  input  logic                        config_write,
  input  logic [tci_pkg::CFG_W-1:0]   config_data,
  output logic                        done,
  output logic [tci_pkg::XY_W-1:0]    value,
  output logic [tci_pkg::ST_W-1:0]    status
);
  import tci_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  tci_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  tci_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .entry_index  (entry_index),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .query_x      (query_x),
    .query_p      (query_p),
    .config_write (config_write),
    .config_data  (config_data),
    .cmd          (cmd),
    .stat         (stat),
    .done         (done),
    .value        (value),
    .status       (status)
  );

endmodule

### sv/tci_checker.sv
// ----------------------------------------------------------------------------
// tci_checker
// Port-level checks of the interpolator's item and result timing.
// ----------------------------------------------------------------------------
module tci_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [tci_pkg::CMD_W-1:0]  command,
  input logic                       done,
  input logic [tci_pkg::XY_W-1:0]   value,
  input logic [tci_pkg::ST_W-1:0]   status
);
  import tci_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an item was taken");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the block is still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_VALID |-> value == '0)
    else $error("nonzero value with a load or error status");

  a_load_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_LOAD |-> ##2
      (done && (status == ST_LOADED || status == ST_RANGE)))
    else $error("load item did not finish two cycles after it was taken");

endmodule

bind tabulated_cdf_interpolator tci_checker u_tci_checker (.*);

### verif/tabulated_cdf_interpolator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabulated_cdf_interpolator_test
// Drives loads, forward lookups and inverse lookups into the interpolator.
// Every result is checked against a cycle-free model of the point table
// kept in the bench.
// ----------------------------------------------------------------------------
module tabulated_cdf_interpolator_test;
  import tci_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam longint Q_MIN  = -64'sd2147483648;
  localparam longint Q_MAX  = 64'sd2147483647;
  localparam longint Q_SPAN = 64'sd4294967295;
  localparam logic [127:0] QUOT_CAP = 128'd1 << QUOT_BITS;
  localparam int TAIL_CYCLES = 200;
  localparam int ITEM_GOAL   = 1950;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] index;
    logic [XY_W-1:0]  ex;
    logic [XY_W-1:0]  ey;
    logic [XY_W-1:0]  qx;
    logic [P_W-1:0]   qp;
    logic [CFG_W-1:0] cfg;
  } step_t;

  typedef struct packed {
    logic [XY_W-1:0] value;
    logic [ST_W-1:0] status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic [XY_W-1:0] entry_x = '0;
  logic [XY_W-1:0] entry_y = '0;
  logic [XY_W-1:0] query_x = '0;
  logic [P_W-1:0] query_p = '0;
  logic config_write = 1'b0;
  logic [CFG_W-1:0] config_data = '0;
  logic done;
  logic [XY_W-1:0] value;
  logic [ST_W-1:0] status;

  tabulated_cdf_interpolator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .entry_index  (entry_index),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .query_x      (query_x),
    .query_p      (query_p),
    .config_write (config_write),
    .config_data  (config_data),
    .done         (done),
    .value        (value),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Point table as the block should hold it, updated when items are taken.
  longint tab_x [TABLE_DEPTH_DEF];
  longint tab_y [TABLE_DEPTH_DEF];
  logic [CFG_W-1:0] tab_count = '0;

  // Mirror of the table as the stimulus generator expects it to become.
  longint gen_x [TABLE_DEPTH_DEF];
  longint gen_y [TABLE_DEPTH_DEF];
  bit gen_written [TABLE_DEPTH_DEF];
  int gen_count = 0;

  step_t pending_steps[$];
  result_t expected_results[$];
  step_t cur_item;

  int item_total = 0;
  int items_sent = 0;
  int settle_cycles = 0;
  int loads_done = 0, forwards_done = 0, inverses_done = 0, unused_done = 0;
  int config_writes = 0, results_checked = 0, mismatch_count = 0;

  function automatic logic [IDX_W-1:0] rnd_idx();
    return IDX_W'($urandom());
  endfunction

  function automatic logic [P_W-1:0] rnd_p();
    return P_W'($urandom());
  endfunction

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // trunc(a*b/d) at full width, magnitude capped at 2^40.
  function automatic longint scaled_quotient(input longint a, input longint b,
                                             input longint d);
    logic [127:0] prod, quo;
    longint ua, ub, ud;
    bit neg;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    ud = (d < 0) ? -d : d;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    if (ua == 0 || ub == 0 || ud == 0) return 0;
    prod = {64'd0, ua} * {64'd0, ub};
    quo = prod / {64'd0, ud};
    if (quo > QUOT_CAP) quo = QUOT_CAP;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic result_t lookup_predict(input step_t s);
    result_t r;
    int n, i;
    longint qx, y0, span, target, xb, yb, xa, ya, sum;
    r.value = '0;
    r.status = ST_RANGE;
    n = (tab_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(tab_count);
    case (s.command)
      CMD_LOAD: begin
        tab_x[s.index] = longint'($signed(s.ex));
        tab_y[s.index] = longint'($signed(s.ey));
        r.status = ST_LOADED;
      end
      CMD_FORWARD: begin
        qx = longint'($signed(s.qx));
        if (n != 0 && qx >= tab_x[0] && qx <= tab_x[n-1]) begin
          i = 0;
          while (i < n && tab_x[i] < qx) i++;
          if (i == 0) begin
            sum = tab_y[0];
          end else if (i == n) begin
            sum = tab_y[n-1];
          end else begin
            xb = tab_x[i-1]; yb = tab_y[i-1];
            xa = tab_x[i];   ya = tab_y[i];
            sum = clamp_q(yb + scaled_quotient(qx - xb, ya - yb, xa - xb));
          end
          r.value = 32'(sum);
          r.status = ST_VALID;
        end
      end
      CMD_INVERSE: begin
        if (n != 0) begin
          y0 = tab_y[0];
          span = tab_y[n-1] - y0;
          if (span < 0) span = -span;
          target = y0 + ((span * longint'(s.qp)) >>> 16);
          i = 0;
          while (i < n && tab_y[i] < target) i++;
          if (i < n) begin
            if (i == 0) begin
              sum = tab_x[0];
            end else begin
              xb = tab_x[i-1]; yb = tab_y[i-1];
              xa = tab_x[i];   ya = tab_y[i];
              sum = clamp_q(xb + scaled_quotient(target - yb, xa - xb, ya - yb));
            end
            r.value = 32'(sum);
            r.status = ST_VALID;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [XY_W-1:0] ex, input logic [XY_W-1:0] ey,
                          input logic [XY_W-1:0] qx, input logic [P_W-1:0] qp);
    step_t s;
    s.kind = STEP_ITEM;
    s.command = cmd;
    s.index = idx;
    s.ex = ex;
    s.ey = ey;
    s.qx = qx;
    s.qp = qp;
    s.cfg = '0;
    pending_steps.push_back(s);
    item_total++;
    if (cmd == CMD_LOAD) begin
      gen_x[idx] = longint'($signed(ex));
      gen_y[idx] = longint'($signed(ey));
      gen_written[idx] = 1'b1;
    end
  endtask

  task automatic add_config(input logic [CFG_W-1:0] c);
    step_t s;
    s = '0;
    s.kind = STEP_CONFIG;
    s.cfg = c;
    pending_steps.push_back(s);
    gen_count = int'(c);
  endtask

  task automatic add_drain();
    step_t s;
    s = '0;
    s.kind = STEP_DRAIN;
    pending_steps.push_back(s);
  endtask

  // Loads slots 0..n-1 with mostly ascending x and mostly CDF-shaped y.
  task automatic add_table(input int n);
    longint xs [TABLE_DEPTH_DEF];
    longint ys [TABLE_DEPTH_DEF];
    longint step_max, v, tmp;
    int i, k, a, b, shape;
    if ($urandom_range(0, 3) == 0) begin
      step_max = Q_SPAN / (n + 1);
      v = Q_MIN + longint'($urandom_range(0, 32'(step_max - 1)));
      for (i = 0; i < n; i++) begin
        xs[i] = v;
        v += longint'($urandom_range(1, 32'(step_max)));
      end
    end else begin
      k = $urandom_range(0, 16);
      v = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
      for (i = 0; i < n; i++) begin
        xs[i] = v;
        v += longint'($urandom_range(1, 1 << k));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      step_max = Q_SPAN / (n + 1);
      v = Q_MIN + longint'($urandom_range(0, 32'(step_max - 1)));
      for (i = 0; i < n; i++) begin
        ys[i] = v;
        v += longint'($urandom_range(0, 32'(step_max)));
      end
    end else begin
      k = $urandom_range(0, 20);
      v = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
      for (i = 0; i < n; i++) begin
        ys[i] = v;
        v += longint'($urandom_range(0, 1 << k));
      end
    end
    shape = $urandom_range(0, 7);
    if (shape == 6) begin
      // Descending y lets an inverse target lie above every point.
      for (i = 0; i < n / 2; i++) begin
        tmp = ys[i];
        ys[i] = ys[n-1-i];
        ys[n-1-i] = tmp;
      end
    end else if (shape == 7) begin
      for (i = 0; i < n; i++) ys[i] = longint'($signed($urandom()));
    end
    if (n >= 2 && $urandom_range(0, 7) == 0) begin
      // An out-of-order pair; the block scans the stored values as they are.
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      tmp = xs[a];
      xs[a] = xs[b];
      xs[b] = tmp;
    end
    for (i = 0; i < n; i++) begin
      add_item(CMD_LOAD, IDX_W'(i), 32'(xs[i]), 32'(ys[i]), $urandom(), rnd_p());
    end
  endtask

  task automatic add_query();
    int pick, n, j;
    longint dx;
    logic [XY_W-1:0] qx;
    logic [P_W-1:0] qp;
    n = (gen_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : gen_count;
    pick = $urandom_range(0, 99);
    qx = $urandom();
    qp = rnd_p();
    if (pick < 40 && n >= 2) begin
      j = $urandom_range(0, n - 2);
      dx = gen_x[j+1] - gen_x[j];
      if (dx > 0) qx = 32'(gen_x[j] + longint'($urandom_range(0, 32'(dx))));
      add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else if (pick < 52 && n >= 1) begin
      qx = 32'(gen_x[$urandom_range(0, n - 1)]);
      add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else if (pick < 60 && n >= 1) begin
      qx = ($urandom_range(0, 1) == 0) ? 32'(gen_x[0] - 1) : 32'(gen_x[n-1] + 1);
      add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else if (pick < 64) begin
      add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else if (pick < 92) begin
      if ($urandom_range(0, 7) == 0) qp = ($urandom_range(0, 1) == 0) ? '0 : '1;
      add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else if (pick < 96) begin
      add_item(CMD_UNUSED, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end else begin
      // Stray load into the live table.
      add_item(CMD_LOAD, rnd_idx(), $urandom(), $urandom(), qx, qp);
    end
  endtask

  // Driver: takes items off the pending queue and presents them.
  always @(posedge clk) begin : drive_proc
    logic accepted, next_start, next_cfg_we;
    step_t nxt;
    int pct;
    if (rst) begin
      start <= 1'b0;
      config_write <= 1'b0;
      settle_cycles <= 0;
    end else begin
      accepted = start && !busy;
      next_start = start && !accepted;
      next_cfg_we = 1'b0;
      if (accepted) begin
        expected_results.push_back(lookup_predict(cur_item));
        items_sent++;
        case (cur_item.command)
          CMD_LOAD:    loads_done++;
          CMD_FORWARD: forwards_done++;
          CMD_INVERSE: inverses_done++;
          default:     unused_done++;
        endcase
      end
      if (expected_results.size() == 0 && !start) settle_cycles <= settle_cycles + 1;
      else settle_cycles <= 0;
      if (!next_start && pending_steps.size() != 0) begin
        nxt = pending_steps[0];
        case (nxt.kind)
          STEP_ITEM: begin
            if (items_sent < item_total / 3) pct = 9;
            else if (items_sent < 2 * item_total / 3) pct = 64;
            else pct = 0;
            if ($urandom_range(0, 99) >= pct) begin
              cur_item = nxt;
              command <= nxt.command;
              entry_index <= nxt.index;
              entry_x <= nxt.ex;
              entry_y <= nxt.ey;
              query_x <= nxt.qx;
              query_p <= nxt.qp;
              next_start = 1'b1;
              void'(pending_steps.pop_front());
            end
          end
          STEP_CONFIG: begin
            // Only touch the register once the block has gone quiet.
            if (!start && !busy && expected_results.size() == 0 && settle_cycles >= 2) begin
              config_data <= nxt.cfg;
              next_cfg_we = 1'b1;
              tab_count = nxt.cfg;
              config_writes++;
              void'(pending_steps.pop_front());
            end
          end
          default: begin
            if (!start && expected_results.size() == 0) void'(pending_steps.pop_front());
          end
        endcase
      end
      start <= next_start;
      config_write <= next_cfg_we;
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst && done) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result value=%h status=%0d", $time, value, status);
      end else begin
        want = expected_results.pop_front();
        if (value !== want.value || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     $time, want.value, want.status, value, status);
        end
      end
    end
  end

  initial begin : stim_proc
    int n, q, c, prefix, r, i;
    bit first;
    for (i = 0; i < TABLE_DEPTH_DEF; i++) begin
      tab_x[i] = 0;
      tab_y[i] = 0;
      gen_written[i] = 1'b0;
    end

    // Empty table and the unused command.
    add_config(7'd0);
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0, rnd_p());
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'h0);
    add_item(CMD_UNUSED, rnd_idx(), $urandom(), $urandom(), $urandom(), rnd_p());
    // Four points spanning the whole coordinate range.
    add_item(CMD_LOAD, 6'd0, 32'h8000_0000, 32'h8000_0000, $urandom(), rnd_p());
    add_item(CMD_LOAD, 6'd1, 32'hFFFF_0000, 32'hFFFF_FC18, $urandom(), rnd_p());
    add_item(CMD_LOAD, 6'd2, 32'h0001_0000, 32'h0000_1388, $urandom(), rnd_p());
    add_item(CMD_LOAD, 6'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom(), rnd_p());
    add_config(7'd4);
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h8000_0000, rnd_p());
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h7FFF_FFFF, rnd_p());
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0000_0000, rnd_p());
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0001_0000, rnd_p());
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'h0000);
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'hFFFF);
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'h8000);
    add_item(CMD_UNUSED, rnd_idx(), $urandom(), $urandom(), $urandom(), rnd_p());
    // Descending y: a high probability finds no point above its target.
    add_item(CMD_LOAD, 6'd0, 32'h0000_0000, 32'h0064_0000, $urandom(), rnd_p());
    add_item(CMD_LOAD, 6'd1, 32'h0001_0000, 32'h0032_0000, $urandom(), rnd_p());
    add_item(CMD_LOAD, 6'd2, 32'h0002_0000, 32'h0000_0000, $urandom(), rnd_p());
    add_config(7'd3);
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'hFFFF);
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'h0000);
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'hFFFF_FFFF, rnd_p());
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0003_0000, rnd_p());
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0000_8000, rnd_p());
    // Single point: zero span on both lookups.
    add_config(7'd1);
    add_item(CMD_FORWARD, rnd_idx(), $urandom(), $urandom(), 32'h0000_0000, rnd_p());
    add_item(CMD_INVERSE, rnd_idx(), $urandom(), $urandom(), $urandom(), 16'h1234);

    first = 1'b1;
    while (item_total < ITEM_GOAL) begin
      r = $urandom_range(0, 11);
      if (first) n = TABLE_DEPTH_DEF;
      else if (r == 0) n = TABLE_DEPTH_DEF;
      else if (r == 1) n = 1;
      else if (r == 2) n = $urandom_range(9, 20);
      else n = $urandom_range(2, 8);
      if ($urandom_range(0, 5) == 0) add_drain();
      add_table(n);
      prefix = 0;
      while (prefix < TABLE_DEPTH_DEF && gen_written[prefix]) prefix++;
      r = $urandom_range(0, 9);
      if (first) c = 127;
      else if (r < 7) c = n;
      else if (r == 7) c = $urandom_range(0, n);
      else c = (prefix == TABLE_DEPTH_DEF) ? $urandom_range(64, 127) : prefix;
      add_config(CFG_W'(c));
      q = $urandom_range(8, 20);
      repeat (q) add_query();
      if (first) begin
        add_config(7'd64);
        repeat (q) add_query();
      end
      first = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_steps.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0d predicted results never arrived", expected_results.size());
    end
    $display("Ran %0d loads, %0d forward and %0d inverse lookups, %0d unused commands.",
             loads_done, forwards_done, inverses_done, unused_done);
    $display("Checked %0d results over %0d register writes; %0d mismatches.",
             results_checked, config_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS tabulated_cdf_interpolator");
    end else begin
      $display("FAIL tabulated_cdf_interpolator");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #50_000_000;
    $display("Timed out with %0d items pending", pending_steps.size());
    $display("FAIL tabulated_cdf_interpolator");
    $finish;
  end

endmodule
